// ----- rtl/core/sg4fc_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the scaled gray4 frame converter.
// Used by the front, queue, back and top level; depends on nothing.
package sg4fc_pkg;

  localparam int unsigned DefSrcDepth   = 65536;
  localparam int unsigned DefPanelWidth = 960;
  localparam int unsigned DefPanelHeight = 540;

  // Fixed field widths
  localparam int unsigned CfgW      = 13;  // source size registers and scaled coordinates
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned ColPairW  = 9;
  localparam int unsigned RowW      = 10;
  localparam int unsigned LoadIdxW  = 16;
  localparam int unsigned ByteAddrW = 18;
  localparam int unsigned RgbW      = 24;
  localparam int unsigned AddrMaxW  = 24;  // store address at the largest store depth

  localparam int unsigned QDepth = 8;
  localparam int unsigned QPtrW  = 3;
  localparam int unsigned QCntW  = 4;

  typedef enum logic [CfgIdxW-1:0] {
    CfgSrcWidth  = 2'd0,
    CfgSrcHeight = 2'd1
  } cfg_idx_e;

  typedef enum logic {
    ReqLoad    = 1'b0,
    ReqConvert = 1'b1
  } req_type_e;

  // One queued item: a store write or a pair of store reads.
  typedef struct packed {
    logic                 is_load;
    logic [AddrMaxW-1:0]  addr0;
    logic [AddrMaxW-1:0]  addr1;
    logic                 oor0;
    logic                 oor1;
    logic [ByteAddrW-1:0] byte_addr;
    logic [RgbW-1:0]      rgb;
  } entry_t;

  typedef struct packed {
    logic             empty;
    logic [QCntW-1:0] count;
  } qstat_t;

endpackage

// ----- rtl/core/scaled_gray4_frame_converter.sv -----
`timescale 1ns / 1ps
// Top level of the scaled gray4 frame converter: front, queue and back.
// Depends on sg4fc_pkg, sg4fc_front, sg4fc_queue and sg4fc_back.
//
// Load requests (req_type 0) write one RGB pixel into a SRC_DEPTH x 24-bit
// store and give no result; convert requests (req_type 1) give one packed
// byte holding two 4-bit grays of nearest-neighbour scaled source pixels
// (even panel column in the low nibble), its frame byte address and a flag
// set when a chosen source index lies beyond the store (that pixel reads as
// white). Loads beyond the store and converts off the panel are dropped.
// One request is taken per cycle when the output is not stalled; a convert
// request passes through four registered steps of scaling arithmetic
// (products, reciprocal multiply, quotient correction, source index), the
// queue, the registered read of both pixels through the store's two read
// ports, and the registered luma and packing before its result appears.
// The store has no reset; read only entries that were loaded.
// Write src_width (index 0) and src_height (index 1) only while idle.
module scaled_gray4_frame_converter #(
  parameter int unsigned SRC_DEPTH    = sg4fc_pkg::DefSrcDepth,
  parameter int unsigned PANEL_WIDTH  = sg4fc_pkg::DefPanelWidth,
  parameter int unsigned PANEL_HEIGHT = sg4fc_pkg::DefPanelHeight
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [sg4fc_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [sg4fc_pkg::CfgW-1:0]       cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             req_type_i,
  input  logic [sg4fc_pkg::LoadIdxW-1:0]   load_index_i,
  input  logic [7:0]                       red_i,
  input  logic [7:0]                       green_i,
  input  logic [7:0]                       blue_i,
  input  logic [sg4fc_pkg::ColPairW-1:0]   column_pair_i,
  input  logic [sg4fc_pkg::RowW-1:0]       panel_row_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [sg4fc_pkg::ByteAddrW-1:0]  byte_addr_o,
  output logic [7:0]                       pixel_byte_o,
  output logic                             out_of_range_o
);

  sg4fc_pkg::qstat_t qstat;
  sg4fc_pkg::entry_t push_entry, head;
  logic              push, pop;

  sg4fc_front #(
    .SRC_DEPTH   (SRC_DEPTH),
    .PANEL_WIDTH (PANEL_WIDTH),
    .PANEL_HEIGHT(PANEL_HEIGHT)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_type_i),
    .load_index_i (load_index_i),
    .red_i        (red_i),
    .green_i      (green_i),
    .blue_i       (blue_i),
    .column_pair_i(column_pair_i),
    .panel_row_i  (panel_row_i),
    .qstat_i      (qstat),
    .push_o       (push),
    .entry_o      (push_entry)
  );

  sg4fc_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(push_entry),
    .pop_i  (pop),
    .head_o (head),
    .stat_o (qstat)
  );

  sg4fc_back #(
    .SRC_DEPTH(SRC_DEPTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .stat_i        (qstat),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .byte_addr_o   (byte_addr_o),
    .pixel_byte_o  (pixel_byte_o),
    .out_of_range_o(out_of_range_o)
  );

endmodule

// ----- rtl/core/sg4fc_front.sv -----
`timescale 1ns / 1ps
// Front part: configuration registers, request intake and the scaling
// pipeline that turns a convert request into two store addresses. Uses sg4fc_pkg.
module sg4fc_front #(
  parameter int unsigned SRC_DEPTH    = sg4fc_pkg::DefSrcDepth,
  parameter int unsigned PANEL_WIDTH  = sg4fc_pkg::DefPanelWidth,
  parameter int unsigned PANEL_HEIGHT = sg4fc_pkg::DefPanelHeight
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [sg4fc_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [sg4fc_pkg::CfgW-1:0]           cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 req_type_i,
  input  logic [sg4fc_pkg::LoadIdxW-1:0]       load_index_i,
  input  logic [7:0]                           red_i,
  input  logic [7:0]                           green_i,
  input  logic [7:0]                           blue_i,
  input  logic [sg4fc_pkg::ColPairW-1:0]       column_pair_i,
  input  logic [sg4fc_pkg::RowW-1:0]           panel_row_i,
  input  sg4fc_pkg::qstat_t                    qstat_i,
  output logic                                 push_o,
  output sg4fc_pkg::entry_t                    entry_o
);

  localparam int unsigned CW     = sg4fc_pkg::CfgW;
  localparam int unsigned XW     = sg4fc_pkg::ColPairW + 1;
  localparam int unsigned YRW    = 12;
  localparam int unsigned ANumW  = XW + CW;
  localparam int unsigned BNumW  = YRW + CW;
  localparam int unsigned APrW   = 2 * ANumW;
  localparam int unsigned BPrW   = 2 * BNumW + 1;
  localparam int unsigned IdxW   = 2 * CW + 1;
  localparam int unsigned BaW    = 23;
  localparam int unsigned LiW    = 25;
  localparam int unsigned SumW   = sg4fc_pkg::QCntW + 1;
  localparam int unsigned HalfW  = PANEL_WIDTH / 2;
  localparam logic [ANumW-1:0] RecipA = ANumW'((64'd1 << ANumW) / PANEL_WIDTH);
  localparam logic [BNumW:0]   RecipB = (BNumW + 1)'((64'd1 << BNumW) / PANEL_HEIGHT);

  // Finish a reciprocal quotient that may be one short.
  function automatic logic [CW-1:0] fix_quot(input logic [BNumW-1:0] n,
                                             input logic [CW-1:0]    qe,
                                             input logic [BNumW-1:0] d);
    logic [BNumW-1:0] r;
    r = n - BNumW'(qe) * d;
    return (r >= d) ? qe + CW'(1) : qe;
  endfunction

  logic [CW-1:0] width_q, height_q;
  logic          portrait;

  // Intake
  logic              acc, is_load, load_ok, conv_ok;
  logic [XW-1:0]     x0, x1;
  logic [YRW-1:0]    yr;
  logic [CW-1:0]     sel_a, sel_b;
  logic [BaW-1:0]    baddr_full;

  logic                             f1_v_q, f2_v_q, f3_v_q, f4_v_q;
  logic                             f1_load_q, f2_load_q, f3_load_q;
  logic [sg4fc_pkg::AddrMaxW-1:0]   f1_laddr_q, f2_laddr_q, f3_laddr_q;
  logic [sg4fc_pkg::RgbW-1:0]       f1_rgb_q, f2_rgb_q, f3_rgb_q;
  logic [sg4fc_pkg::ByteAddrW-1:0]  f1_baddr_q, f2_baddr_q, f3_baddr_q;
  logic                             f1_port_q, f2_port_q;
  logic [ANumW-1:0]                 f1_a0_q, f1_a1_q, f2_a0_q, f2_a1_q;
  logic [BNumW-1:0]                 f1_b_q, f2_b_q;
  logic [CW-1:0]                    f2_qa0_q, f2_qa1_q, f2_qb_q;
  logic [CW-1:0]                    f3_srow0_q, f3_scol0_q, f3_srow1_q, f3_scol1_q;
  sg4fc_pkg::entry_t                f4_entry_q, f4_entry_d;

  logic [APrW-1:0] pr_a0, pr_a1;
  logic [BPrW-1:0] pr_b;
  logic [CW-1:0]   q_a0, q_a1, q_b;
  logic [IdxW-1:0] idx0, idx1;
  logic [SumW-1:0] load_sum;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CW'(1);
      height_q <= CW'(1);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        sg4fc_pkg::CfgSrcWidth:  width_q  <= cfg_data_i;
        sg4fc_pkg::CfgSrcHeight: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign portrait = height_q > width_q;

  // Hold intake while the queue could not take everything already in flight.
  assign load_sum = SumW'(qstat_i.count) + SumW'(f1_v_q) + SumW'(f2_v_q)
                  + SumW'(f3_v_q) + SumW'(f4_v_q);
  assign in_stall_o = load_sum >= SumW'(sg4fc_pkg::QDepth);

  assign acc     = in_valid_i && !in_stall_o;
  assign is_load = req_type_i == sg4fc_pkg::ReqLoad;
  assign load_ok = LiW'(load_index_i) < LiW'(SRC_DEPTH);
  assign conv_ok = (CW'(panel_row_i) < CW'(PANEL_HEIGHT)) && (CW'(column_pair_i) < CW'(HalfW));

  assign x0    = {column_pair_i, 1'b0};
  assign x1    = {column_pair_i, 1'b1};
  assign sel_a = portrait ? height_q : width_q;
  assign sel_b = portrait ? width_q : height_q;
  // Portrait: the source column runs against the panel row.
  assign yr    = portrait ? YRW'(PANEL_HEIGHT - 1) - YRW'(panel_row_i) : YRW'(panel_row_i);
  assign baddr_full = BaW'(panel_row_i) * BaW'(HalfW) + BaW'(column_pair_i);

  // Reciprocal multiply: quotient estimate, at most one short.
  assign pr_a0 = APrW'(f1_a0_q) * APrW'(RecipA);
  assign pr_a1 = APrW'(f1_a1_q) * APrW'(RecipA);
  assign pr_b  = BPrW'(f1_b_q) * BPrW'(RecipB);

  assign q_a0 = fix_quot(BNumW'(f2_a0_q), f2_qa0_q, BNumW'(PANEL_WIDTH));
  assign q_a1 = fix_quot(BNumW'(f2_a1_q), f2_qa1_q, BNumW'(PANEL_WIDTH));
  assign q_b  = fix_quot(f2_b_q, f2_qb_q, BNumW'(PANEL_HEIGHT));

  assign idx0 = IdxW'(f3_srow0_q) * IdxW'(width_q) + IdxW'(f3_scol0_q);
  assign idx1 = IdxW'(f3_srow1_q) * IdxW'(width_q) + IdxW'(f3_scol1_q);

  always_comb begin
    f4_entry_d.is_load   = f3_load_q;
    f4_entry_d.addr0     = f3_load_q ? f3_laddr_q : idx0[sg4fc_pkg::AddrMaxW-1:0];
    f4_entry_d.addr1     = idx1[sg4fc_pkg::AddrMaxW-1:0];
    f4_entry_d.oor0      = idx0 >= IdxW'(SRC_DEPTH);
    f4_entry_d.oor1      = idx1 >= IdxW'(SRC_DEPTH);
    f4_entry_d.byte_addr = f3_baddr_q;
    f4_entry_d.rgb       = f3_rgb_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_v_q <= 1'b0;
      f2_v_q <= 1'b0;
      f3_v_q <= 1'b0;
      f4_v_q <= 1'b0;
    end else begin
      // Drop loads beyond the store and converts off the panel here.
      f1_v_q <= acc && (is_load ? load_ok : conv_ok);
      f2_v_q <= f1_v_q;
      f3_v_q <= f2_v_q;
      f4_v_q <= f3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    f1_load_q  <= is_load;
    f1_laddr_q <= sg4fc_pkg::AddrMaxW'(load_index_i);
    f1_rgb_q   <= {red_i, green_i, blue_i};
    f1_baddr_q <= baddr_full[sg4fc_pkg::ByteAddrW-1:0];
    f1_port_q  <= portrait;
    f1_a0_q    <= ANumW'(x0) * ANumW'(sel_a);
    f1_a1_q    <= ANumW'(x1) * ANumW'(sel_a);
    f1_b_q     <= BNumW'(yr) * BNumW'(sel_b);

    f2_load_q  <= f1_load_q;
    f2_laddr_q <= f1_laddr_q;
    f2_rgb_q   <= f1_rgb_q;
    f2_baddr_q <= f1_baddr_q;
    f2_port_q  <= f1_port_q;
    f2_a0_q    <= f1_a0_q;
    f2_a1_q    <= f1_a1_q;
    f2_b_q     <= f1_b_q;
    f2_qa0_q   <= pr_a0[ANumW +: CW];
    f2_qa1_q   <= pr_a1[ANumW +: CW];
    f2_qb_q    <= pr_b[BNumW +: CW];

    f3_load_q  <= f2_load_q;
    f3_laddr_q <= f2_laddr_q;
    f3_rgb_q   <= f2_rgb_q;
    f3_baddr_q <= f2_baddr_q;
    f3_srow0_q <= f2_port_q ? q_a0 : q_b;
    f3_scol0_q <= f2_port_q ? q_b : q_a0;
    f3_srow1_q <= f2_port_q ? q_a1 : q_b;
    f3_scol1_q <= f2_port_q ? q_b : q_a1;

    f4_entry_q <= f4_entry_d;
  end

  assign push_o  = f4_v_q;
  assign entry_o = f4_entry_q;

endmodule

// ----- rtl/core/sg4fc_queue.sv -----
`timescale 1ns / 1ps
// Short queue between the front and back parts. Uses sg4fc_pkg.
// The front only pushes when a slot is reserved for it.
module sg4fc_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  sg4fc_pkg::entry_t entry_i,
  input  logic              pop_i,
  output sg4fc_pkg::entry_t head_o,
  output sg4fc_pkg::qstat_t stat_o
);

  sg4fc_pkg::entry_t                slots_q [sg4fc_pkg::QDepth];
  logic [sg4fc_pkg::QPtrW-1:0]      wr_ptr_q, rd_ptr_q;
  logic [sg4fc_pkg::QCntW-1:0]      cnt_q, cnt_d;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + sg4fc_pkg::QCntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - sg4fc_pkg::QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + sg4fc_pkg::QPtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + sg4fc_pkg::QPtrW'(1);
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= entry_i;
    end
  end

  assign head_o       = slots_q[rd_ptr_q];
  assign stat_o.empty = cnt_q == '0;
  assign stat_o.count = cnt_q;

endmodule

// ----- rtl/core/sg4fc_back.sv -----
`timescale 1ns / 1ps
// Back part: source pixel store with one write and two read ports, luma and
// nibble packing, and the output register. Uses sg4fc_pkg.
module sg4fc_back #(
  parameter int unsigned SRC_DEPTH = sg4fc_pkg::DefSrcDepth
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  sg4fc_pkg::qstat_t                   stat_i,
  input  sg4fc_pkg::entry_t                   head_i,
  output logic                                pop_o,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [sg4fc_pkg::ByteAddrW-1:0]     byte_addr_o,
  output logic [7:0]                          pixel_byte_o,
  output logic                                out_of_range_o
);

  localparam int unsigned AW = $clog2(SRC_DEPTH);
  localparam int unsigned LumaW = 24;
  localparam logic [LumaW-1:0] LumaR = LumaW'(19595);
  localparam logic [LumaW-1:0] LumaG = LumaW'(38470);
  localparam logic [LumaW-1:0] LumaB = LumaW'(7471);
  localparam logic [3:0] WhiteGray = 4'hF;

  function automatic logic [3:0] gray4(input logic [sg4fc_pkg::RgbW-1:0] rgb);
    logic [LumaW-1:0] luma;
    luma = LumaW'(rgb[23:16]) * LumaR + LumaW'(rgb[15:8]) * LumaG
         + LumaW'(rgb[7:0]) * LumaB;
    return luma[LumaW-1 -: 4];
  endfunction

  logic [sg4fc_pkg::RgbW-1:0]       mem_q [SRC_DEPTH];
  logic [sg4fc_pkg::RgbW-1:0]       rd0_q, rd1_q;
  logic                             b1_v_q;
  logic                             b1_oor0_q, b1_oor1_q;
  logic [sg4fc_pkg::ByteAddrW-1:0]  b1_baddr_q;
  logic                             out_v_q;
  logic [sg4fc_pkg::ByteAddrW-1:0]  out_baddr_q;
  logic [7:0]                       out_byte_q;
  logic                             out_oor_q;
  logic                             ready1, ready2, pop;
  logic [3:0]                       gray_lo, gray_hi;

  assign ready2 = !out_v_q || !out_stall_i;
  assign ready1 = !b1_v_q || ready2;
  assign pop    = !stat_i.empty && ready1;
  assign pop_o  = pop;

  // Loads write in queue order, so a later convert always sees them.
  always_ff @(posedge clk_i) begin
    if (pop && head_i.is_load) begin
      mem_q[head_i.addr0[AW-1:0]] <= head_i.rgb;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && !head_i.is_load) begin
      rd0_q <= mem_q[head_i.addr0[AW-1:0]];
      rd1_q <= mem_q[head_i.addr1[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && !head_i.is_load) begin
      b1_oor0_q  <= head_i.oor0;
      b1_oor1_q  <= head_i.oor1;
      b1_baddr_q <= head_i.byte_addr;
    end
  end

  assign gray_lo = b1_oor0_q ? WhiteGray : gray4(rd0_q);
  assign gray_hi = b1_oor1_q ? WhiteGray : gray4(rd1_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (ready1) begin
        b1_v_q <= pop && !head_i.is_load;
      end
      if (ready2) begin
        out_v_q <= b1_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready2 && b1_v_q) begin
      out_baddr_q <= b1_baddr_q;
      out_byte_q  <= {gray_hi, gray_lo};
      out_oor_q   <= b1_oor0_q || b1_oor1_q;
    end
  end

  assign out_valid_o    = out_v_q;
  assign byte_addr_o    = out_baddr_q;
  assign pixel_byte_o   = out_byte_q;
  assign out_of_range_o = out_oor_q;

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of scaled_gray4_frame_converter: random requests under
// random sender gaps and receiver stalls, checked by a scoreboard with its own predictor.
// Depends on sg4fc_pkg and the scaled_gray4_frame_converter RTL.
module tb;
  import sg4fc_pkg::*;

  localparam int unsigned SrcDepth    = DefSrcDepth;
  localparam int unsigned PanelWidth  = DefPanelWidth;
  localparam int unsigned PanelHeight = DefPanelHeight;
  localparam int unsigned PairCount   = PanelWidth / 2;
  localparam int unsigned FlushCycles = 24;    // margin for the request-to-result path, plus queue
  localparam int unsigned IdleLimit   = 2000;
  localparam int unsigned PhaseCount  = 13;
  localparam int unsigned PhaseItems  = 90;

  // Predicts the packed frame bytes and keeps the ones still owed by the block.
  class gray_frame_scoreboard;
    typedef struct {
      logic [ByteAddrW-1:0] addr;
      logic [7:0]           pix;
      logic                 oor;
    } frame_byte_t;

    logic [RgbW-1:0] src_pixels [SrcDepth];
    bit              loaded [SrcDepth];
    logic [CfgW-1:0] width;
    logic [CfgW-1:0] height;
    frame_byte_t     owed_q[$];
    int unsigned     failures;
    int unsigned     loads_noted;
    int unsigned     converts_noted;
    int unsigned     ignored_noted;
    int unsigned     oor_noted;
    int unsigned     bytes_checked;

    function new();
      width  = 1;
      height = 1;
    endfunction

    function void set_register(cfg_idx_e idx, logic [CfgW-1:0] value);
      if (idx == CfgSrcWidth) width = value;
      else if (idx == CfgSrcHeight) height = value;
    endfunction

    // Nearest-neighbour source index under panel column px, row py.
    function longint unsigned source_index(int unsigned px, int unsigned py);
      longint unsigned w;
      longint unsigned h;
      longint unsigned srow;
      longint unsigned scol;
      w = width;
      h = height;
      if (h > w) begin
        srow = px * h / PanelWidth;
        scol = (PanelHeight - 1 - py) * w / PanelHeight;
      end else begin
        srow = py * h / PanelHeight;
        scol = px * w / PanelWidth;
      end
      return srow * w + scol;
    endfunction

    function logic [3:0] gray_of(int unsigned px, int unsigned py, inout logic oor);
      longint unsigned idx;
      logic [RgbW-1:0] pix;
      int unsigned     luma;
      idx = source_index(px, py);
      if (idx >= SrcDepth) begin
        oor = 1'b1;
        return 4'hF;
      end
      pix  = src_pixels[idx];
      luma = (19595 * pix[23:16] + 38470 * pix[15:8] + 7471 * pix[7:0]) >> 16;
      return luma[7:4];
    endfunction

    function void note_request(req_type_e kind, logic [LoadIdxW-1:0] li,
                               logic [7:0] r, logic [7:0] g, logic [7:0] b,
                               logic [ColPairW-1:0] cp, logic [RowW-1:0] row);
      frame_byte_t want;
      logic        oor;
      logic [3:0]  lo;
      logic [3:0]  hi;
      if (kind == ReqLoad) begin
        if (li < SrcDepth) begin
          src_pixels[li] = {r, g, b};
          loaded[li]     = 1'b1;
          loads_noted++;
        end
        return;
      end
      if (row >= PanelHeight || cp >= PairCount) begin
        ignored_noted++;
        return;
      end
      oor = 1'b0;
      lo  = gray_of(2 * cp, row, oor);
      hi  = gray_of(2 * cp + 1, row, oor);
      want.addr = row * PairCount + cp;
      want.pix  = {hi, lo};
      want.oor  = oor;
      owed_q.insert(owed_q.size(), want);
      converts_noted++;
      if (oor) oor_noted++;
    endfunction

    function void check_result(logic [ByteAddrW-1:0] addr, logic [7:0] pix, logic oor);
      frame_byte_t want;
      if (owed_q.size() == 0) begin
        $error("unexpected frame byte: byte_addr %0d pixel_byte 0x%02h", addr, pix);
        failures++;
        return;
      end
      want = owed_q.pop_front();
      bytes_checked++;
      if (addr !== want.addr) begin
        $error("byte_addr: expected %0d, actual %0d", want.addr, addr);
        failures++;
      end
      if (pix !== want.pix) begin
        $error("pixel_byte: expected 0x%02h, actual 0x%02h", want.pix, pix);
        failures++;
      end
      if (oor !== want.oor) begin
        $error("out_of_range: expected %0b, actual %0b", want.oor, oor);
        failures++;
      end
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction

    // Every accepted request, dropped ones included.
    function int unsigned items_noted();
      return loads_noted + converts_noted + ignored_noted;
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index_i;
  logic [CfgW-1:0]      cfg_data_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic                 req_type_i;
  logic [LoadIdxW-1:0]  load_index_i;
  logic [7:0]           red_i;
  logic [7:0]           green_i;
  logic [7:0]           blue_i;
  logic [ColPairW-1:0]  column_pair_i;
  logic [RowW-1:0]      panel_row_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [ByteAddrW-1:0] byte_addr_o;
  logic [7:0]           pixel_byte_o;
  logic                 out_of_range_o;

  gray_frame_scoreboard sb = new();

  int unsigned burst_left;
  int unsigned idle_cycles;
  int unsigned stall_mode;
  int unsigned stall_left;
  int unsigned cycle_count;
  int unsigned sizes_run;

  scaled_gray4_frame_converter uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .load_index_i   (load_index_i),
    .red_i          (red_i),
    .green_i        (green_i),
    .blue_i         (blue_i),
    .column_pair_i  (column_pair_i),
    .panel_row_i    (panel_row_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .byte_addr_o    (byte_addr_o),
    .pixel_byte_o   (pixel_byte_o),
    .out_of_range_o (out_of_range_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Receiver: check accepted bytes, stall in randomly chosen modes, each held for a random span.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result(byte_addr_o, pixel_byte_o, out_of_range_o);
    end
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(50, 400);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      2: out_stall_i <= ($urandom_range(0, 3) != 0);
      default: out_stall_i <= (cycle_count % 5 < 2);
    endcase
  end

  // Watchdog: any accepted request, result or register write resets the count.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("[scaled_gray4_frame_converter] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Hold the request until accepted, then advance the burst or drop valid for a gap.
  task automatic send_request(req_type_e kind, logic [LoadIdxW-1:0] li,
                              logic [7:0] r, logic [7:0] g, logic [7:0] b,
                              logic [ColPairW-1:0] cp, logic [RowW-1:0] row);
    int unsigned gap;
    in_valid_i    <= 1'b1;
    req_type_i    <= kind;
    load_index_i  <= li;
    red_i         <= r;
    green_i       <= g;
    blue_i        <= b;
    column_pair_i <= cp;
    panel_row_i   <= row;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(kind, li, r, g, b, cp, row);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 15) : $urandom_range(0, 3);
      if (gap > 0) in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(150, 300)
                                               : $urandom_range(1, 24);
    end
  endtask

  task automatic load_pixel(logic [LoadIdxW-1:0] li, logic [7:0] r, logic [7:0] g,
                            logic [7:0] b);
    send_request(ReqLoad, li, r, g, b, $urandom_range(0, 511), $urandom_range(0, 1023));
  endtask

  // Load every in-store source pixel the pair will read that was never loaded.
  task automatic convert_pair(logic [ColPairW-1:0] cp, logic [RowW-1:0] row);
    longint unsigned idx;
    for (int unsigned px = 2 * cp; px <= 2 * cp + 1; px++) begin
      idx = sb.source_index(px, row);
      if (idx < SrcDepth && !sb.loaded[idx]) begin
        load_pixel(idx, $urandom_range(0, 255), $urandom_range(0, 255),
                   $urandom_range(0, 255));
      end
    end
    send_request(ReqConvert, $urandom_range(0, 65535), $urandom_range(0, 255),
                 $urandom_range(0, 255), $urandom_range(0, 255), cp, row);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (FlushCycles) @(posedge clk_i);
  endtask

  task automatic write_size(logic [CfgW-1:0] w, logic [CfgW-1:0] h);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CfgSrcWidth;
    cfg_data_i  <= w;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_register(CfgSrcWidth, w);
    cfg_index_i <= CfgSrcHeight;
    cfg_data_i  <= h;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_register(CfgSrcHeight, h);
    cfg_valid_i <= 1'b0;
    sizes_run++;
  endtask

  function automatic logic [ColPairW-1:0] pick_pair();
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return PairCount - 1;
      2, 3:    return $urandom_range(0, 7);
      default: return $urandom_range(0, PairCount - 1);
    endcase
  endfunction

  function automatic logic [RowW-1:0] pick_row();
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return PanelHeight - 1;
      2, 3:    return $urandom_range(0, 7);
      default: return $urandom_range(0, PanelHeight - 1);
    endcase
  endfunction

  initial begin
    int unsigned phase_w [PhaseCount];
    int unsigned phase_h [PhaseCount];
    int unsigned start_items;
    int unsigned sel;
    bit          paused;

    phase_w = '{960, 540, 4096, 1, 4096, 0, 8191, 0, 37, 64, 48, 1, 1};
    phase_h = '{540, 960, 4096, 4096, 1, 0, 8191, 37, 0, 48, 64, 1, 1};
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CfgSrcWidth;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    req_type_i    = ReqLoad;
    load_index_i  = '0;
    red_i         = '0;
    green_i       = '0;
    blue_i        = '0;
    column_pair_i = '0;
    panel_row_i   = '0;
    out_stall_i   = 1'b0;
    burst_left    = 0;
    idle_cycles   = 0;
    stall_mode    = 0;
    stall_left    = 0;
    cycle_count   = 0;
    sizes_run     = 1;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset size 1x1: every panel pixel reads source pixel 0.
    load_pixel(0, 8'hFF, 8'hFF, 8'hFF);
    convert_pair(0, 0);
    load_pixel(0, 8'h00, 8'h00, 8'h00);
    convert_pair(PairCount - 1, PanelHeight - 1);
    load_pixel(0, 8'hFF, 8'h00, 8'h00);
    convert_pair(PairCount - 1, 0);
    load_pixel(0, 8'h00, 8'hFF, 8'h00);
    convert_pair(0, PanelHeight - 1);
    load_pixel(0, 8'h00, 8'h00, 8'hFF);
    convert_pair(PairCount / 2, PanelHeight / 2);
    load_pixel(16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
    load_pixel(16'h5555, 8'h80, 8'h7F, 8'h01);
    send_request(ReqConvert, 0, 0, 0, 0, PairCount, 0);
    send_request(ReqConvert, 0, 0, 0, 0, 0, PanelHeight);
    send_request(ReqConvert, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 9'h1FF, 10'h3FF);
    convert_pair(PairCount - 1, PanelHeight - 1);

    phase_w[PhaseCount-2] = $urandom_range(1, 300);
    phase_h[PhaseCount-2] = $urandom_range(1, 300);
    phase_w[PhaseCount-1] = $urandom_range(1, 4096);
    phase_h[PhaseCount-1] = $urandom_range(1, 4096);

    for (int unsigned p = 0; p < PhaseCount; p++) begin
      drain_results();
      write_size(phase_w[p], phase_h[p]);
      @(posedge clk_i);
      convert_pair(0, 0);
      convert_pair(PairCount - 1, PanelHeight - 1);
      start_items = sb.items_noted();
      paused      = 1'b0;
      while (sb.items_noted() - start_items < PhaseItems) begin
        if (!paused && p % 3 == 0 &&
            sb.items_noted() - start_items >= PhaseItems / 2) begin
          drain_results();
          paused = 1'b1;
        end
        sel = $urandom_range(0, 99);
        if (sel < 60) begin
          convert_pair(pick_pair(), pick_row());
        end else if (sel < 85) begin
          load_pixel($urandom_range(0, 65535), $urandom_range(0, 255),
                     $urandom_range(0, 255), $urandom_range(0, 255));
        end else if (sel < 93) begin
          send_request(ReqConvert, $urandom_range(0, 65535), $urandom_range(0, 255),
                       $urandom_range(0, 255), $urandom_range(0, 255),
                       $urandom_range(PairCount, 511), $urandom_range(0, 1023));
        end else begin
          send_request(ReqConvert, $urandom_range(0, 65535), $urandom_range(0, 255),
                       $urandom_range(0, 255), $urandom_range(0, 255),
                       $urandom_range(0, 511), $urandom_range(PanelHeight, 1023));
        end
      end
    end

    drain_results();
    if (sb.pending() != 0) begin
      $error("%0d frame bytes never arrived", sb.pending());
      sb.failures++;
    end
    $display("Checked %0d frame bytes (%0d reading past the store) from %0d pixel loads,",
             sb.bytes_checked, sb.oor_noted, sb.loads_noted);
    $display("%0d off-panel converts dropped, %0d source sizes used.",
             sb.ignored_noted, sizes_run);
    if (sb.failures == 0) begin
      $display("[scaled_gray4_frame_converter] OK");
    end else begin
      $display("[scaled_gray4_frame_converter] ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/sg4fc_pkg.sv
rtl/core/sg4fc_front.sv
rtl/core/sg4fc_queue.sv
rtl/core/sg4fc_back.sv
rtl/core/scaled_gray4_frame_converter.sv
tb/tb.sv
